>>> rtl/core/apo_pkg.sv
package apo_pkg;

   localparam int AXIS_BITS          = 16;
   localparam int PROJ_OUT_BITS      = 33;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 4;
   localparam int QUEUE_PTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_BITS      = 4;
   localparam int CSR_DATA_BITS      = 32;
   localparam int RSP_FIELD_BITS     = 1 + 4 * PROJ_OUT_BITS;
   localparam int RSP_DATA_BITS      = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic signed [AXIS_BITS-1:0] AXIS_X_RESET = 16'sd16384;
   localparam logic signed [AXIS_BITS-1:0] AXIS_Y_RESET = 16'sd0;
   localparam logic signed [AXIS_BITS-1:0] AXIS_Z_RESET = 16'sd0;

   typedef enum logic [1:0] {
      REG_AXIS_X = 2'd0,
      REG_AXIS_Y = 2'd1,
      REG_AXIS_Z = 2'd2
   } apo_reg_type;

   // Classification of a vertex that travels with its projection.
   typedef struct packed {
      logic shape_b;
      logic last;
   } apo_tag_type;

   typedef struct packed {
      logic                      empty;
      logic [QUEUE_CNT_BITS-1:0] count;
   } apo_queue_status_type;

endpackage

>>> rtl/core/apo_front.sv
module apo_front
   import apo_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int REQ_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8,
   parameter int PROJ_BITS = COORD_BITS + AXIS_BITS + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                      req_tuser,
   input  logic                      req_tlast,
   input  apo_queue_status_type      queue_status,
   output logic                      push_valid,
   output logic signed [PROJ_BITS-1:0] push_proj,
   output apo_tag_type               push_tag
);

   localparam int PROD_BITS = COORD_BITS + AXIS_BITS;

   logic signed [AXIS_BITS-1:0] axis_x_ff, axis_x_in;
   logic signed [AXIS_BITS-1:0] axis_y_ff, axis_y_in;
   logic signed [AXIS_BITS-1:0] axis_z_ff, axis_z_in;
   apo_reg_type                 reg_index;
   logic                        csr_write;

   logic signed [COORD_BITS-1:0] vx, vy, vz;
   logic                         accept;

   logic                        s1_valid_ff, s1_valid_in;
   apo_tag_type                 s1_tag_ff;
   logic signed [PROD_BITS-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_BITS-1:0] prod_x_in, prod_y_in, prod_z_in;

   logic                        s2_valid_ff, s2_valid_in;
   apo_tag_type                 s2_tag_ff;
   logic signed [PROJ_BITS-1:0] proj_ff, proj_in;

   logic [QUEUE_CNT_BITS:0]     committed;

   assign reg_index = apo_reg_type'(csr_paddr[3:2]);
   assign csr_write = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      axis_x_in  = axis_x_ff;
      axis_y_in  = axis_y_ff;
      axis_z_in  = axis_z_ff;
      csr_prdata = '0;
      case (reg_index)
         REG_AXIS_X: begin
            if (csr_write) axis_x_in = csr_pwdata[AXIS_BITS-1:0];
            csr_prdata = CSR_DATA_BITS'(axis_x_ff);
         end
         REG_AXIS_Y: begin
            if (csr_write) axis_y_in = csr_pwdata[AXIS_BITS-1:0];
            csr_prdata = CSR_DATA_BITS'(axis_y_ff);
         end
         REG_AXIS_Z: begin
            if (csr_write) axis_z_in = csr_pwdata[AXIS_BITS-1:0];
            csr_prdata = CSR_DATA_BITS'(axis_z_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff <= AXIS_X_RESET;
         axis_y_ff <= AXIS_Y_RESET;
         axis_z_ff <= AXIS_Z_RESET;
      end else begin
         axis_x_ff <= axis_x_in;
         axis_y_ff <= axis_y_in;
         axis_z_ff <= axis_z_in;
      end
   end

   // Every request in the two pipeline stages owns a queue slot, so the
   // pipeline never has to stall.
   assign committed = (QUEUE_CNT_BITS + 1)'(queue_status.count)
                    + (QUEUE_CNT_BITS + 1)'(s1_valid_ff)
                    + (QUEUE_CNT_BITS + 1)'(s2_valid_ff);
   assign req_tready = (committed < (QUEUE_CNT_BITS + 1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid & req_tready;

   assign vx = req_tdata[COORD_BITS-1:0];
   assign vy = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign vz = req_tdata[3*COORD_BITS-1:2*COORD_BITS];

   always_comb begin
      prod_x_in   = PROD_BITS'(vx) * PROD_BITS'(axis_x_ff);
      prod_y_in   = PROD_BITS'(vy) * PROD_BITS'(axis_y_ff);
      prod_z_in   = PROD_BITS'(vz) * PROD_BITS'(axis_z_ff);
      s1_valid_in = accept;
      proj_in     = PROJ_BITS'(prod_x_ff) + PROJ_BITS'(prod_y_ff) + PROJ_BITS'(prod_z_ff);
      s2_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff         <= prod_x_in;
      prod_y_ff         <= prod_y_in;
      prod_z_ff         <= prod_z_in;
      s1_tag_ff.shape_b <= req_tuser;
      s1_tag_ff.last    <= req_tlast;
      proj_ff           <= proj_in;
      s2_tag_ff         <= s1_tag_ff;
   end

   assign push_valid = s2_valid_ff;
   assign push_proj  = proj_ff;
   assign push_tag   = s2_tag_ff;

endmodule

>>> rtl/core/apo_queue.sv
module apo_queue
   import apo_pkg::*;
#(
   parameter int DATA_BITS = COORD_BITS_DEFAULT + AXIS_BITS + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  apo_tag_type          push_tag,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] head_data,
   output apo_tag_type          head_tag,
   output apo_queue_status_type status
);

   logic [DATA_BITS-1:0]      data_ff [QUEUE_DEPTH];
   apo_tag_type               tag_ff  [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
         tag_ff[wr_ptr_ff]  <= push_tag;
      end
   end

   assign head_data    = data_ff[rd_ptr_ff];
   assign head_tag     = tag_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("request pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from an empty queue");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && pop |=> $stable(count_ff))
      else $error("queue level moved on a simultaneous push and pop");

endmodule

>>> rtl/core/apo_back.sv
module apo_back
   import apo_pkg::*;
#(
   parameter int PROJ_BITS = COORD_BITS_DEFAULT + AXIS_BITS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  apo_queue_status_type        queue_status,
   input  logic signed [PROJ_BITS-1:0] head_proj,
   input  apo_tag_type                 head_tag,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_DATA_BITS-1:0]    rsp_tdata
);

   logic signed [PROJ_BITS-1:0] a_min_ff, a_min_in, a_max_ff, a_max_in;
   logic signed [PROJ_BITS-1:0] b_min_ff, b_min_in, b_max_ff, b_max_in;
   logic                        seen_a_ff, seen_a_in, seen_b_ff, seen_b_in;
   logic signed [PROJ_BITS-1:0] res_a_min, res_a_max, res_b_min, res_b_max;
   logic                        res_hit;

   logic                        out_valid_ff, out_valid_in;
   logic                        out_hit_ff;
   logic signed [PROJ_BITS-1:0] out_a_min_ff, out_a_max_ff, out_b_min_ff, out_b_max_ff;
   logic signed [PROJ_OUT_BITS-1:0] f_a_min, f_a_max, f_b_min, f_b_max;
   logic                        load;

   // A vertex that does not end the pair never waits for the output side.
   assign pop  = !queue_status.empty && (!head_tag.last || !out_valid_ff || rsp_tready);
   assign load = pop && head_tag.last;

   always_comb begin
      a_min_in  = a_min_ff;
      a_max_in  = a_max_ff;
      b_min_in  = b_min_ff;
      b_max_in  = b_max_ff;
      seen_a_in = seen_a_ff;
      seen_b_in = seen_b_ff;
      if (pop) begin
         if (head_tag.shape_b) begin
            if (!seen_b_ff || head_proj < b_min_ff) b_min_in = head_proj;
            if (!seen_b_ff || head_proj > b_max_ff) b_max_in = head_proj;
            seen_b_in = 1'b1;
         end else begin
            if (!seen_a_ff || head_proj < a_min_ff) a_min_in = head_proj;
            if (!seen_a_ff || head_proj > a_max_ff) a_max_in = head_proj;
            seen_a_in = 1'b1;
         end
      end
      res_a_min = seen_a_in ? a_min_in : '0;
      res_a_max = seen_a_in ? a_max_in : '0;
      res_b_min = seen_b_in ? b_min_in : '0;
      res_b_max = seen_b_in ? b_max_in : '0;
      res_hit   = seen_a_in && seen_b_in && (res_a_min <= res_b_max)
                  && (res_b_min <= res_a_max);
      if (load) begin
         seen_a_in = 1'b0;
         seen_b_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_min_ff     <= '0;
         a_max_ff     <= '0;
         b_min_ff     <= '0;
         b_max_ff     <= '0;
         seen_a_ff    <= 1'b0;
         seen_b_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_min_ff     <= a_min_in;
         a_max_ff     <= a_max_in;
         b_min_ff     <= b_min_in;
         b_max_ff     <= b_max_in;
         seen_a_ff    <= seen_a_in;
         seen_b_ff    <= seen_b_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_hit_ff   <= res_hit;
         out_a_min_ff <= res_a_min;
         out_a_max_ff <= res_a_max;
         out_b_min_ff <= res_b_min;
         out_b_max_ff <= res_b_max;
      end
   end

   // The result fields carry the low bits of the projection, sign-extended
   // when the projection is narrower than the field.
   generate
      if (PROJ_BITS >= PROJ_OUT_BITS) begin : g_trunc
         assign f_a_min = out_a_min_ff[PROJ_OUT_BITS-1:0];
         assign f_a_max = out_a_max_ff[PROJ_OUT_BITS-1:0];
         assign f_b_min = out_b_min_ff[PROJ_OUT_BITS-1:0];
         assign f_b_max = out_b_max_ff[PROJ_OUT_BITS-1:0];
      end else begin : g_extend
         assign f_a_min = PROJ_OUT_BITS'(out_a_min_ff);
         assign f_a_max = PROJ_OUT_BITS'(out_a_max_ff);
         assign f_b_min = PROJ_OUT_BITS'(out_b_min_ff);
         assign f_b_max = PROJ_OUT_BITS'(out_b_max_ff);
      end
   endgenerate

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({f_b_max, f_b_min, f_a_max, f_a_min, out_hit_ff});

   a_load_on_free: assert property (@(posedge clock) disable iff (reset)
      load |-> !out_valid_ff || rsp_tready)
      else $error("result overwritten before it was taken");

   a_seen_cleared: assert property (@(posedge clock) disable iff (reset)
      load |=> !seen_a_ff && !seen_b_ff)
      else $error("shape flags not cleared after a result");

   a_hit_needs_both: assert property (@(posedge clock) disable iff (reset)
      load && res_hit |-> seen_a_in == 1'b0 && (seen_a_ff || !head_tag.shape_b)
                          && (seen_b_ff || head_tag.shape_b))
      else $error("overlap reported with an empty shape");

endmodule

>>> rtl/core/axis_projection_overlap_test.sv
// Channel   Direction  Handshake             Payload
// req       in         req_tvalid/tready     tdata {z, y, x}, tuser shape_b, tlast last
// rsp       out        rsp_tvalid/tready     tdata {b_max, b_min, a_max, a_min, overlap}
// csr       in         APB, pready tied high axis_x @0x0, axis_y @0x4, axis_z @0x8
//
// One vertex request is taken per cycle while req_tready is high. A request
// passes three multipliers, an adder stage and a four-entry queue before the
// min/max update, and the result of a pair is registered before rsp_tvalid.
// Reset is synchronous; it restores the axis to (1.0, 0, 0) and empties both
// intervals. A stalled result holds a pair's last vertex at the queue head and
// every vertex behind it; req_tready drops once the queue slots run out.
module axis_projection_overlap_test
   import apo_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tdata: vertex_x, vertex_y, vertex_z (COORD_BITS each), zero padding
   input  logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: in_shape_b
   input  logic                     req_tuser,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // tdata: intervals_overlap (1 bit), a_min, a_max, b_min, b_max (33 each), zero padding
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int REQ_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8;
   localparam int PROJ_BITS     = COORD_BITS + AXIS_BITS + 1;

   apo_queue_status_type        queue_status;
   logic                        push_valid;
   logic signed [PROJ_BITS-1:0] push_proj;
   apo_tag_type                 push_tag;
   logic [PROJ_BITS-1:0]        head_data;
   apo_tag_type                 head_tag;
   logic                        pop;

   assign csr_pready = 1'b1;

   apo_front #(
      .COORD_BITS    (COORD_BITS),
      .REQ_DATA_BITS (REQ_DATA_BITS),
      .PROJ_BITS     (PROJ_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_proj    (push_proj),
      .push_tag     (push_tag)
   );

   apo_queue #(
      .DATA_BITS (PROJ_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_proj),
      .push_tag  (push_tag),
      .pop       (pop),
      .head_data (head_data),
      .head_tag  (head_tag),
      .status    (queue_status)
   );

   apo_back #(
      .PROJ_BITS (PROJ_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_proj    ($signed(head_data)),
      .head_tag     (head_tag),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule
